>>> rtl/core/bf5h_pkg.sv
// ----------------------------------------------------------------------------
// bf5h_pkg
// Shared constants, types and helper functions for the five-hash Bloom filter.
// ----------------------------------------------------------------------------
package bf5h_pkg;

    localparam int TABLE_DEPTH = 131072;
    localparam int NUM_HASH    = 5;
    localparam int SEL_W       = $clog2(NUM_HASH);
    localparam int CFG_W       = 18;
    localparam int LETTER_W    = 5;
    localparam int MULT_W      = 15;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int HASH_W      = IDX_W;
    localparam int MOD_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PROD_W      = HASH_W + MULT_W;
    localparam int RED_STEPS   = (PROD_W + 1) / 2;
    localparam int PAD_W       = 2 * RED_STEPS;
    localparam int STEP_W      = $clog2(RED_STEPS);

    localparam logic [CFG_W-1:0] MOD_RESET [NUM_HASH] = '{
        18'd44701, 18'd47701, 18'd90709, 18'd78487, 18'd65537
    };

    localparam logic [SEL_W-1:0] SEL_A = SEL_W'(0);
    localparam logic [SEL_W-1:0] SEL_B = SEL_W'(1);
    localparam logic [SEL_W-1:0] SEL_C = SEL_W'(2);
    localparam logic [SEL_W-1:0] SEL_D = SEL_W'(3);
    localparam logic [SEL_W-1:0] SEL_E = SEL_W'(4);

    typedef struct packed {
        logic                start;
        logic [SEL_W-1:0]    sel;
        logic [HASH_W-1:0]   hash;
        logic [LETTER_W-1:0] letter;
        logic [MOD_W-1:0]    modulus;
    } hash_req_t;

    typedef struct packed {
        logic              done;
        logic [HASH_W-1:0] hash;
    } hash_rsp_t;

    function automatic logic [MULT_W-1:0] hash_mult(input logic [SEL_W-1:0] sel);
        logic [MULT_W-1:0] p;
        begin
            unique case (sel)
                SEL_A:   p = MULT_W'(18143);
                SEL_B:   p = MULT_W'(20749);
                SEL_C:   p = MULT_W'(17419);
                SEL_D:   p = MULT_W'(22853);
                SEL_E:   p = MULT_W'(19949);
                default: p = '0;
            endcase
            return p;
        end
    endfunction

    // Clamp a modulus register into 2 .. TABLE_DEPTH.
    function automatic logic [MOD_W-1:0] effective_modulus(input logic [CFG_W-1:0] r);
        logic [MOD_W-1:0] m;
        begin
            if (32'(r) < 32'd2)
            begin
                m = MOD_W'(2);
            end
            else if (32'(r) > 32'(TABLE_DEPTH))
            begin
                m = MOD_W'(TABLE_DEPTH);
            end
            else
            begin
                m = MOD_W'(r);
            end
            return m;
        end
    endfunction

endpackage

>>> rtl/core/bf5h_ram.sv
// ----------------------------------------------------------------------------
// bf5h_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bf5h_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> rtl/core/bf5h_hash_unit.sv
// ----------------------------------------------------------------------------
// bf5h_hash_unit
// Shared hash step: one multiply, then a two-bit-per-cycle restoring
// reduction modulo the selected register.
// ----------------------------------------------------------------------------
module bf5h_hash_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  bf5h_pkg::hash_req_t  req,
    output bf5h_pkg::hash_rsp_t  rsp
);

    typedef enum logic {
        U_IDLE,
        U_REDUCE
    } unit_state_t;

    unit_state_t                      state_reg;
    unit_state_t                      state_next;
    logic [bf5h_pkg::PAD_W-1:0]       prod_reg;
    logic [bf5h_pkg::PAD_W-1:0]       prod_next;
    logic [bf5h_pkg::MOD_W-1:0]       mod_reg;
    logic [bf5h_pkg::MOD_W-1:0]       rem_reg;
    logic [bf5h_pkg::STEP_W-1:0]      step_reg;
    logic                             done_reg;
    logic [bf5h_pkg::HASH_W-1:0]      hash_reg;
    logic [bf5h_pkg::MOD_W:0]         trial_hi;
    logic [bf5h_pkg::MOD_W-1:0]       rem_hi;
    logic [bf5h_pkg::MOD_W:0]         trial_lo;
    logic [bf5h_pkg::MOD_W-1:0]       rem_lo;
    logic                             last_step;

    assign prod_next = bf5h_pkg::PAD_W'(req.hash)
                     * bf5h_pkg::PAD_W'(bf5h_pkg::hash_mult(req.sel))
                     + bf5h_pkg::PAD_W'(req.letter);

    assign last_step = (step_reg == bf5h_pkg::STEP_W'(bf5h_pkg::RED_STEPS - 1));

    always_comb
    begin
        trial_hi = {rem_reg, prod_reg[bf5h_pkg::PAD_W-1]};
        if (trial_hi >= {1'b0, mod_reg})
        begin
            rem_hi = bf5h_pkg::MOD_W'(trial_hi - {1'b0, mod_reg});
        end
        else
        begin
            rem_hi = bf5h_pkg::MOD_W'(trial_hi);
        end
        trial_lo = {rem_hi, prod_reg[bf5h_pkg::PAD_W-2]};
        if (trial_lo >= {1'b0, mod_reg})
        begin
            rem_lo = bf5h_pkg::MOD_W'(trial_lo - {1'b0, mod_reg});
        end
        else
        begin
            rem_lo = bf5h_pkg::MOD_W'(trial_lo);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            U_IDLE:
            begin
                if (req.start)
                begin
                    state_next = U_REDUCE;
                end
            end
            U_REDUCE:
            begin
                if (last_step)
                begin
                    state_next = U_IDLE;
                end
            end
            default: state_next = U_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            prod_reg  <= '0;
            mod_reg   <= '0;
            rem_reg   <= '0;
            step_reg  <= '0;
            done_reg  <= 1'b0;
            hash_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == U_REDUCE) && last_step;
            unique case (state_reg)
                U_IDLE:
                begin
                    if (req.start)
                    begin
                        prod_reg <= prod_next;
                        mod_reg  <= req.modulus;
                        rem_reg  <= '0;
                        step_reg <= '0;
                    end
                end
                U_REDUCE:
                begin
                    prod_reg <= prod_reg << 2;
                    rem_reg  <= rem_lo;
                    step_reg <= step_reg + 1'b1;
                    if (last_step)
                    begin
                        hash_reg <= bf5h_pkg::HASH_W'(rem_lo);
                    end
                end
                default: ;
            endcase
        end
    end

    assign rsp.done = done_reg;
    assign rsp.hash = hash_reg;

endmodule

>>> rtl/core/bloom_filter_five_hash_top.sv
// Each letter runs five hash steps on one shared multiply and two-bit-per-cycle
// reduction unit. A letter that is not the last then returns to idle; a last
// letter goes on to read and check the five bit tables and then presents its
// result, holding it while the output is stalled. One letter at a time.
// After reset a clearing pass zeroes the tables; letters stall during it,
// configuration writes are taken.
// ----------------------------------------------------------------------------
// bloom_filter_five_hash_top
// Five-table Bloom filter fed one key letter per request, with a modulus
// register per hash and a per-key query or query-and-insert result.
// ----------------------------------------------------------------------------
module bloom_filter_five_hash_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bf5h_pkg::LETTER_W-1:0] letter,
    input  logic                          last_letter,
    input  logic                          opcode,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          all_present,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bf5h_pkg::SEL_W-1:0]    cfg_index,
    input  logic [bf5h_pkg::CFG_W-1:0]    cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH_START,
        S_HASH_WAIT,
        S_PROBE_RD,
        S_PROBE_CHK,
        S_OUT
    } state_t;

    state_t                             state_reg;
    state_t                             state_next;
    logic [bf5h_pkg::SEL_W-1:0]         sel_reg;
    logic [bf5h_pkg::LETTER_W-1:0]      letter_reg;
    logic                               last_reg;
    logic                               opcode_reg;
    logic [bf5h_pkg::HASH_W-1:0]        acc_reg [bf5h_pkg::NUM_HASH];
    logic [bf5h_pkg::CFG_W-1:0]         modulus_reg [bf5h_pkg::NUM_HASH];
    logic [bf5h_pkg::IDX_W-1:0]         clear_cnt_reg;
    logic                               res_reg;
    logic                               out_valid_reg;
    logic                               all_present_reg;
    logic [bf5h_pkg::NUM_HASH-1:0]      rd_bits;
    logic                               in_accept;
    logic                               out_free;
    logic                               clear_done;
    logic                               sel_last;
    bf5h_pkg::hash_req_t                hash_req;
    bf5h_pkg::hash_rsp_t                hash_rsp;

    assign in_accept  = in_valid && (state_reg == S_IDLE);
    assign out_free   = !out_valid_reg || !out_stall;
    assign clear_done = (clear_cnt_reg == bf5h_pkg::IDX_W'(bf5h_pkg::TABLE_DEPTH - 1));
    assign sel_last   = (sel_reg == bf5h_pkg::SEL_W'(bf5h_pkg::NUM_HASH - 1));

    assign hash_req.start   = (state_reg == S_HASH_START);
    assign hash_req.sel     = sel_reg;
    assign hash_req.hash    = acc_reg[sel_reg];
    assign hash_req.letter  = letter_reg;
    assign hash_req.modulus = bf5h_pkg::effective_modulus(modulus_reg[sel_reg]);

    bf5h_hash_unit u_hash (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (hash_req),
        .rsp   (hash_rsp)
    );

    for (genvar g = 0; g < bf5h_pkg::NUM_HASH; g++)
    begin : g_table
        logic [bf5h_pkg::IDX_W-1:0] tbl_addr;
        logic                       tbl_we;

        assign tbl_addr = (state_reg == S_CLEAR) ? clear_cnt_reg : acc_reg[g];
        assign tbl_we   = (state_reg == S_CLEAR)
                       || ((state_reg == S_PROBE_CHK) && opcode_reg);

        bf5h_ram #(
            .WIDTH (1),
            .DEPTH (bf5h_pkg::TABLE_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (tbl_we),
            .addr  (tbl_addr),
            .wdata (state_reg == S_PROBE_CHK),
            .rdata (rd_bits[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (clear_done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_HASH_START;
                end
            end
            S_HASH_START: state_next = S_HASH_WAIT;
            S_HASH_WAIT:
            begin
                if (hash_rsp.done)
                begin
                    priority if (!sel_last)
                    begin
                        state_next = S_HASH_START;
                    end
                    else if (last_reg)
                    begin
                        state_next = S_PROBE_RD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_PROBE_RD:  state_next = S_PROBE_CHK;
            S_PROBE_CHK: state_next = S_OUT;
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            sel_reg         <= '0;
            letter_reg      <= '0;
            last_reg        <= 1'b0;
            opcode_reg      <= 1'b0;
            clear_cnt_reg   <= '0;
            res_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
            all_present_reg <= 1'b0;
            for (int i = 0; i < bf5h_pkg::NUM_HASH; i++)
            begin
                acc_reg[i]     <= '0;
                modulus_reg[i] <= bf5h_pkg::MOD_RESET[i];
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && (cfg_index < bf5h_pkg::SEL_W'(bf5h_pkg::NUM_HASH)))
            begin
                modulus_reg[cfg_index] <= cfg_data;
            end

            if (out_valid_reg && !out_stall && (state_reg != S_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_CLEAR:
                begin
                    clear_cnt_reg <= clear_cnt_reg + 1'b1;
                end
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        letter_reg <= letter;
                        last_reg   <= last_letter;
                        opcode_reg <= opcode;
                        sel_reg    <= '0;
                    end
                end
                S_HASH_WAIT:
                begin
                    if (hash_rsp.done)
                    begin
                        acc_reg[sel_reg] <= hash_rsp.hash;
                        if (!sel_last)
                        begin
                            sel_reg <= sel_reg + 1'b1;
                        end
                    end
                end
                S_PROBE_CHK:
                begin
                    // tables are read at the old indices; clear hashes for the next key
                    res_reg <= &rd_bits;
                    for (int i = 0; i < bf5h_pkg::NUM_HASH; i++)
                    begin
                        acc_reg[i] <= '0;
                    end
                end
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg   <= 1'b1;
                        all_present_reg <= res_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    assign in_stall    = (state_reg != S_IDLE);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign all_present = all_present_reg;

endmodule

>>> rtl/core/bf5h_checker.sv
// ----------------------------------------------------------------------------
// bf5h_checker
// Port-level checks on the Bloom filter top, attached by bind.
// ----------------------------------------------------------------------------
module bf5h_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_stall,
    input logic out_valid,
    input logic out_stall,
    input logic all_present
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(all_present))
        else $error("stalled result changed");

    a_busy_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("took a second letter while one is in progress");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !$rose(out_valid))
        else $error("result appeared one cycle after a request");

endmodule

bind bloom_filter_five_hash_top bf5h_checker u_bf5h_checker (.*);

>>> tb/sv/tb_bloom_filter_five_hash_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bloom_filter_five_hash_top
// Feeds keys letter by letter into the five-table Bloom filter and checks each
// per-key all_present result against a behavioral model of the five hashes
// and bit tables. Moduli sweep through clamped, minimum, maximum and random
// settings. Both sides stall at random, with one long output hold-off.
// ----------------------------------------------------------------------------
module tb_bloom_filter_five_hash_top;
    import bf5h_pkg::*;

    localparam int unsigned HASH_MULT [NUM_HASH] = '{18143, 20749, 17419, 22853, 19949};
    localparam int SETTLE_CYCLES    = 120;
    localparam int LONG_HOLD_CYCLES = 1500;
    localparam int LONG_HOLD_AFTER  = 60;
    localparam int DRAIN_LIMIT      = 400000;
    localparam int PHASE_LETTERS    = 50;
    localparam int NUM_PHASES       = 8;
    localparam int MAX_KEY_LEN      = 8;
    localparam int LETTER_MAX       = (1 << LETTER_W) - 1;
    localparam int KEY_W            = LETTER_W * MAX_KEY_LEN;

    typedef struct packed {
        logic [LETTER_W-1:0] letter;
        logic                last;
        logic                insert;
    } letter_req_t;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_stall;
    logic [LETTER_W-1:0] letter      = '0;
    logic                last_letter = 1'b0;
    logic                opcode      = 1'b0;
    logic                out_valid;
    logic                out_stall   = 1'b0;
    logic                all_present;
    logic                cfg_valid   = 1'b0;
    logic                cfg_ready;
    logic [SEL_W-1:0]    cfg_index   = '0;
    logic [CFG_W-1:0]    cfg_data    = '0;

    logic              no_idle = 1'b0;
    letter_req_t       pending_letters[$];
    logic              expected_present[$];
    logic [KEY_W-1:0]  key_book[$];
    int                key_book_len[$];
    int                letters_queued = 0;
    int                letters_taken  = 0;
    int                error_count    = 0;
    int                results_seen    = 0;
    int                long_hold_left  = 0;
    logic              long_hold_armed = 1'b1;

    logic [CFG_W-1:0]  modulus_reg [NUM_HASH] = MOD_RESET;
    logic [HASH_W-1:0] hash_acc [NUM_HASH]    = '{default: '0};
    bit                bit_table [NUM_HASH][TABLE_DEPTH];

    bloom_filter_five_hash_top DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .letter      (letter),
        .last_letter (last_letter),
        .opcode      (opcode),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .all_present (all_present),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [MOD_W-1:0] clamp_modulus(input logic [CFG_W-1:0] r);
        if (r < 2)
            return MOD_W'(2);
        if (r > TABLE_DEPTH)
            return MOD_W'(TABLE_DEPTH);
        return MOD_W'(r);
    endfunction

    task automatic hash_and_probe(input letter_req_t req);
        logic [63:0] product;
        int          hits;
        hits = 0;
        for (int k = 0; k < NUM_HASH; k++)
        begin
            product     = 64'(hash_acc[k]) * 64'(HASH_MULT[k]) + 64'(req.letter);
            hash_acc[k] = HASH_W'(product % 64'(clamp_modulus(modulus_reg[k])));
        end
        if (req.last)
        begin
            for (int k = 0; k < NUM_HASH; k++)
            begin
                if (bit_table[k][hash_acc[k]])
                    hits++;
                else if (req.insert)
                    bit_table[k][hash_acc[k]] = 1'b1;
                hash_acc[k] = '0;
            end
            expected_present.push_back(hits == NUM_HASH);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : letter_driver
        letter_req_t nxt;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                hash_and_probe(letter_req_t'{letter, last_letter, opcode});
                letters_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_letters.size() != 0 && (no_idle || $urandom_range(99) >= 10))
                begin
                    nxt = pending_letters.pop_front();
                    letter      <= nxt.letter;
                    last_letter <= nxt.last;
                    opcode      <= nxt.insert;
                    in_valid    <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : present_monitor
        logic want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_present.size() == 0)
                begin
                    $error("all_present: expected no result, got %0b", all_present);
                    error_count++;
                end
                else
                begin
                    want = expected_present.pop_front();
                    if (all_present !== want)
                    begin
                        $error("all_present: expected %0b, got %0b", want, all_present);
                        error_count++;
                    end
                end
            end
            // hold off once for a long stretch so the block backs up
            if (long_hold_left != 0)
            begin
                out_stall <= 1'b1;
                long_hold_left--;
            end
            else if (long_hold_armed && results_seen >= LONG_HOLD_AFTER)
            begin
                long_hold_armed = 1'b0;
                long_hold_left  = LONG_HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !no_idle && ($urandom_range(99) < 10);
            end
        end
    end

    task automatic write_modulus(input logic [SEL_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        if (idx < NUM_HASH)
            modulus_reg[idx] = value;
    endtask

    task automatic wait_idle();
        int n;
        n = 0;
        while (n < DRAIN_LIMIT &&
               !(letters_taken == letters_queued && expected_present.size() == 0))
        begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic push_letter(input logic [LETTER_W-1:0] value, input logic last,
                               input logic insert);
        pending_letters.push_back(letter_req_t'{value, last, insert});
        letters_queued++;
    endtask

    task automatic push_key(input logic [KEY_W-1:0] word, input int len, input logic insert);
        for (int i = 0; i < len; i++)
            push_letter(word[i*LETTER_W +: LETTER_W], i == len - 1,
                        (i == len - 1) ? insert : logic'($urandom_range(1)));
        if (insert)
        begin
            key_book.push_back(word);
            key_book_len.push_back(len);
        end
    endtask

    task automatic push_random_key();
        logic [KEY_W-1:0] word;
        int               len;
        int               pick;
        // replay a stored key now and then so hits stay common
        if (key_book.size() != 0 && $urandom_range(99) < 35)
        begin
            pick = $urandom_range(key_book.size() - 1);
            push_key(key_book[pick], key_book_len[pick], logic'($urandom_range(1)));
        end
        else
        begin
            len  = ($urandom_range(9) == 0) ? $urandom_range(MAX_KEY_LEN, 5)
                                            : $urandom_range(4, 1);
            word = '0;
            for (int i = 0; i < len; i++)
                word[i*LETTER_W +: LETTER_W] = ($urandom_range(15) == 0)
                    ? LETTER_W'($urandom_range(LETTER_MAX, 26))
                    : LETTER_W'($urandom_range(25));
            push_key(word, len, logic'($urandom_range(1)));
        end
    endtask

    function automatic logic [CFG_W-1:0] random_modulus();
        case ($urandom_range(5))
            0:       return CFG_W'($urandom_range(1));
            1:       return CFG_W'($urandom_range(16, 2));
            2:       return CFG_W'(TABLE_DEPTH);
            3:       return CFG_W'($urandom_range((1 << CFG_W) - 1, TABLE_DEPTH + 1));
            default: return CFG_W'($urandom_range(TABLE_DEPTH, 2));
        endcase
    endfunction

    initial
    begin : stimulus
        logic [CFG_W-1:0] sweep;
        int               phase_start;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        push_key(KEY_W'(0), 1, 1'b1);
        push_key(KEY_W'(0), 1, 1'b0);
        push_key(KEY_W'(25), 1, 1'b0);
        push_key(KEY_W'(LETTER_MAX), 1, 1'b1);
        push_key(KEY_W'({5'd1, 5'd0}), 2, 1'b1);
        push_key(KEY_W'({5'd1, 5'd0}), 2, 1'b0);
        push_key(KEY_W'({5'd0, 5'd1}), 2, 1'b0);
        push_key(KEY_W'({5'd12, 5'd0, 5'd31, 5'd25}), 4, 1'b0);

        // change a modulus between letters of one key
        push_letter(5'd2, 1'b0, 1'b1);
        push_letter(5'd3, 1'b0, 1'b1);
        wait_idle();
        write_modulus(SEL_A, CFG_W'(3));
        push_letter(5'd4, 1'b1, 1'b1);
        push_key(KEY_W'({5'd4, 5'd3, 5'd2}), 3, 1'b0);
        wait_idle();
        write_modulus(SEL_B, random_modulus());
        write_modulus(SEL_C, random_modulus());
        write_modulus(SEL_D, random_modulus());
        write_modulus(SEL_E, random_modulus());

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            for (int k = 0; k < NUM_HASH; k++)
            begin
                case (phase)
                    0:       sweep = CFG_W'(0);
                    1:       sweep = CFG_W'(2);
                    2:       sweep = CFG_W'(TABLE_DEPTH);
                    3:       sweep = CFG_W'((1 << CFG_W) - 1);
                    default: sweep = random_modulus();
                endcase
                write_modulus(SEL_W'(k), sweep);
            end
            for (int k = NUM_HASH; k < (1 << SEL_W); k++)
                write_modulus(SEL_W'(k), CFG_W'($urandom));
            no_idle <= (phase == NUM_PHASES - 3);
            phase_start = letters_queued;
            while (letters_queued < phase_start + PHASE_LETTERS)
                push_random_key();
            wait_idle();
        end

        if (expected_present.size() != 0)
        begin
            $error("all_present: %0d results never arrived", expected_present.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

>>> bloom_filter_five_hash_top.f
rtl/core/bf5h_pkg.sv
rtl/core/bf5h_ram.sv
rtl/core/bf5h_hash_unit.sv
rtl/core/bloom_filter_five_hash_top.sv
rtl/core/bf5h_checker.sv
tb/sv/tb_bloom_filter_five_hash_top.sv
